// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, muted while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clk edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/mfcc_pkg.sv =====
package mfcc_pkg;

  localparam int MAX_TOUCHES_DEF = 16;

  localparam int ID_W      = 16;
  localparam int ACT_W     = 2;
  localparam int VERDICT_W = 3;

  // contact actions
  localparam logic [ACT_W-1:0] ACT_UP     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DOWN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHANGE = 2'd2;

  // frame verdicts
  localparam logic [VERDICT_W-1:0] V_OK       = 3'd0;
  localparam logic [VERDICT_W-1:0] V_FIRST    = 3'd1;
  localparam logic [VERDICT_W-1:0] V_MANY_UP  = 3'd2;
  localparam logic [VERDICT_W-1:0] V_REAPPEAR = 3'd3;
  localparam logic [VERDICT_W-1:0] V_MISSING  = 3'd4;
  localparam logic [VERDICT_W-1:0] V_OVERFLOW = 3'd5;

  // one stored contact
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [ACT_W-1:0] act;
    logic             vld;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            shift;   // store the new contact, chain moves one place
    logic            commit;  // frame end: current frame becomes previous
    logic            match;   // mark held previous entries with this id
  } bcast_t;

  // per-cell compare results
  typedef struct packed {
    logic up_hit;      // previous up entry with this id
    logic free_hit;    // previous held entry with this id, not yet matched
    logic cur_up_dup;  // current up entry with this id already stored
    logic miss;        // previous held entry still unmatched after this item
  } flags_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [ID_W-1:0]      offending_id;
    logic                 warning;
  } res_t;

  function automatic logic is_held(input logic [ACT_W-1:0] a);
    return (a == ACT_DOWN) || (a == ACT_CHANGE);
  endfunction

endpackage

// ===== hw/rtl/mfcc_cell.sv =====
// One slot: a previous-frame entry with its match bit, and one place of the
// current-frame shift chain.
module mfcc_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  mfcc_pkg::bcast_t bc,
  input  mfcc_pkg::entry_t up_entry,
  output mfcc_pkg::entry_t cur_entry,
  output mfcc_pkg::flags_t flags
);

  mfcc_pkg::entry_t cur_nxt;
  logic [mfcc_pkg::ID_W-1:0]  cur_id_r;
  logic [mfcc_pkg::ACT_W-1:0] cur_act_r;
  logic cur_vld_r;
  logic [mfcc_pkg::ID_W-1:0]  prev_id_r;
  logic [mfcc_pkg::ACT_W-1:0] prev_act_r;
  logic prev_vld_r;
  logic matched_r, matched_nxt;
  logic prev_held, prev_up, hit;

  assign cur_entry.id  = cur_id_r;
  assign cur_entry.act = cur_act_r;
  assign cur_entry.vld = cur_vld_r;

  assign cur_nxt   = bc.shift ? up_entry : cur_entry;
  assign prev_held = prev_vld_r && mfcc_pkg::is_held(prev_act_r);
  assign prev_up   = prev_vld_r && !mfcc_pkg::is_held(prev_act_r);
  assign hit       = (prev_id_r == bc.id);

  assign matched_nxt = matched_r || (bc.match && prev_held && hit);

  assign flags.up_hit     = prev_up && hit;
  assign flags.free_hit   = prev_held && hit && !matched_r;
  assign flags.cur_up_dup = cur_vld_r && !mfcc_pkg::is_held(cur_act_r) && (cur_id_r == bc.id);
  assign flags.miss       = prev_held && !matched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r  <= 1'b0;
      prev_vld_r <= 1'b0;
      matched_r  <= 1'b0;
    end else if (bc.commit) begin
      cur_vld_r  <= 1'b0;
      prev_vld_r <= cur_nxt.vld;
      matched_r  <= 1'b0;
    end else begin
      cur_vld_r  <= cur_nxt.vld;
      matched_r  <= matched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_id_r  <= cur_nxt.id;
    cur_act_r <= cur_nxt.act;
    if (bc.commit) begin
      prev_id_r  <= cur_nxt.id;
      prev_act_r <= cur_nxt.act;
    end
  end

endmodule

// ===== hw/rtl/mfcc_out_buf.sv =====
// Result register with one skid slot behind it.
module mfcc_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mfcc_pkg::res_t  push_data,
  input  logic            out_stall,
  output logic            out_valid,
  output mfcc_pkg::res_t  out_data,
  output logic            full
);

  logic main_vld_r, main_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  mfcc_pkg::res_t main_r, main_nxt;
  mfcc_pkg::res_t skid_r, skid_nxt;
  logic pop;

  assign pop = main_vld_r && !out_stall;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!main_vld_r || pop) begin
      main_vld_nxt = push;
      main_nxt     = push_data;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_vld_r;
  assign out_data  = main_r;
  assign full      = skid_vld_r;

endmodule

// ===== hw/rtl/multitouch_frame_consistency_checker.sv =====
//  channel | direction | handshake          | item
//  --------+-----------+--------------------+-----------------------------------------
//  in_     | input     | in_valid/in_stall  | contact_id, contact_action, frame_end
//  out_    | output    | out_valid/out_stall| verdict, offending_id, transition_warning
//
//  One contact is taken every cycle while in_stall is low; the id is compared against all
//  MAX_TOUCHES cells at once, so nothing loops back across cycles.
//  A frame-end item's result is registered before it shows on out_, via the skid slot if needed.
//  Synchronous active-low reset clears all valid bits and flags; no sweep.
//  in_stall rises only when the result register and its skid slot are
//  both full, i.e. out_ has held a result through out_stall for a while.
module multitouch_frame_consistency_checker #(
  parameter int MAX_TOUCHES = mfcc_pkg::MAX_TOUCHES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mfcc_pkg::ID_W-1:0]        in_contact_id,
  input  logic [mfcc_pkg::ACT_W-1:0]       in_contact_action,
  input  logic                             in_frame_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mfcc_pkg::VERDICT_W-1:0]   out_verdict,
  output logic [mfcc_pkg::ID_W-1:0]        out_offending_id,
  output logic                             out_transition_warning
);

  // ---------------------------------------------------------------------
  // Frame-level state
  // ---------------------------------------------------------------------
  logic have_prev_r;
  logic prev_many_up_r, prev_many_up_nxt;   // previous frame had >1 distinct up id
  logic lift_one_r, lift_one_nxt;           // current frame: distinct up ids seen
  logic lift_many_r, lift_many_nxt;
  logic ovf_r, ovf_nxt;
  logic err3_r, err3_nxt;
  logic [mfcc_pkg::ID_W-1:0] bad_id_r, bad_id_nxt;
  logic trans_r, trans_nxt;
  logic warn_r, warn_nxt;

  logic in_acc, frame_done, full, store, proc, reap, note, new_up, missing;
  logic up_hit_any, free_hit_any, dup_any;

  mfcc_pkg::bcast_t bc;
  mfcc_pkg::entry_t head_entry;
  mfcc_pkg::entry_t cur_entry [MAX_TOUCHES];
  mfcc_pkg::flags_t flg       [MAX_TOUCHES];
  logic [MAX_TOUCHES-1:0] up_hit_v, free_hit_v, dup_v, miss_v;
  mfcc_pkg::res_t res;

  assign in_acc     = in_valid && !in_stall;
  assign frame_done = in_acc && in_frame_end;
  // the last cell holding a contact means the frame buffer is full
  assign full       = cur_entry[MAX_TOUCHES-1].vld;
  assign store      = in_acc && !full;

  assign head_entry.id  = in_contact_id;
  assign head_entry.act = in_contact_action;
  assign head_entry.vld = 1'b1;

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  genvar g;
  generate
    for (g = 0; g < MAX_TOUCHES; g++) begin : g_cell
      if (g == 0) begin : g_head
        mfcc_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .bc       (bc),
          .up_entry (head_entry),
          .cur_entry(cur_entry[g]),
          .flags    (flg[g])
        );
      end else begin : g_body
        mfcc_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .bc       (bc),
          .up_entry (cur_entry[g-1]),
          .cur_entry(cur_entry[g]),
          .flags    (flg[g])
        );
      end
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < MAX_TOUCHES; i++) begin
      up_hit_v[i]   = flg[i].up_hit;
      free_hit_v[i] = flg[i].free_hit;
      dup_v[i]      = flg[i].cur_up_dup;
      miss_v[i]     = flg[i].miss;
    end
  end

  assign up_hit_any   = |up_hit_v;
  assign free_hit_any = |free_hit_v;
  assign dup_any      = |dup_v;
  assign missing      = |miss_v;

  // ---------------------------------------------------------------------
  // Per-contact check against the previous frame
  // ---------------------------------------------------------------------
  // Checking stops at the first reappeared up id, and is skipped entirely
  // when the previous frame already fails on several lifted ids.
  assign proc = store && have_prev_r && !prev_many_up_r && !err3_r;
  assign reap = proc && up_hit_any;
  assign note = proc && !reap &&
                ((!free_hit_any && (in_contact_action == mfcc_pkg::ACT_DOWN)) ||
                 (in_contact_action == mfcc_pkg::ACT_UP));

  assign bc.id     = in_contact_id;
  assign bc.shift  = store;
  assign bc.commit = frame_done;
  assign bc.match  = proc && !reap && free_hit_any;

  assign err3_nxt   = err3_r || reap;
  assign bad_id_nxt = reap ? in_contact_id : bad_id_r;
  assign trans_nxt  = trans_r || note;
  assign warn_nxt   = warn_r || (note && trans_r);
  assign ovf_nxt    = ovf_r || (in_acc && full);

  // distinct up ids of the frame being recorded (action 3 counts as up)
  assign new_up        = store && !mfcc_pkg::is_held(in_contact_action) && !dup_any;
  assign lift_one_nxt  = lift_one_r || new_up;
  assign lift_many_nxt = lift_many_r || (new_up && lift_one_r);
  assign prev_many_up_nxt = frame_done ? lift_many_nxt : prev_many_up_r;

  // ---------------------------------------------------------------------
  // Verdict at frame end
  // ---------------------------------------------------------------------
  always_comb begin
    res.verdict      = mfcc_pkg::V_OK;
    res.offending_id = '0;
    res.warning      = warn_nxt;
    if (ovf_nxt) begin
      res.verdict = mfcc_pkg::V_OVERFLOW;
      res.warning = 1'b0;
    end else if (!have_prev_r) begin
      res.verdict = mfcc_pkg::V_FIRST;
      res.warning = 1'b0;
    end else if (prev_many_up_r) begin
      res.verdict = mfcc_pkg::V_MANY_UP;
      res.warning = 1'b0;
    end else if (err3_nxt) begin
      res.verdict      = mfcc_pkg::V_REAPPEAR;
      res.offending_id = bad_id_nxt;
    end else if (missing) begin
      res.verdict = mfcc_pkg::V_MISSING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r    <= 1'b0;
      prev_many_up_r <= 1'b0;
      lift_one_r     <= 1'b0;
      lift_many_r    <= 1'b0;
      ovf_r          <= 1'b0;
      err3_r         <= 1'b0;
      trans_r        <= 1'b0;
      warn_r         <= 1'b0;
    end else begin
      prev_many_up_r <= prev_many_up_nxt;
      if (frame_done) begin
        have_prev_r <= 1'b1;
        lift_one_r  <= 1'b0;
        lift_many_r <= 1'b0;
        ovf_r       <= 1'b0;
        err3_r      <= 1'b0;
        trans_r     <= 1'b0;
        warn_r      <= 1'b0;
      end else begin
        lift_one_r  <= lift_one_nxt;
        lift_many_r <= lift_many_nxt;
        ovf_r       <= ovf_nxt;
        err3_r      <= err3_nxt;
        trans_r     <= trans_nxt;
        warn_r      <= warn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    bad_id_r <= bad_id_nxt;
  end

  // ---------------------------------------------------------------------
  // Result buffer
  // ---------------------------------------------------------------------
  mfcc_pkg::res_t out_data;

  mfcc_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (frame_done),
    .push_data(res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .full     (in_stall)
  );

  assign out_verdict            = out_data.verdict;
  assign out_offending_id       = out_data.offending_id;
  assign out_transition_warning = out_data.warning;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_CLK(a_stall_needs_out, in_stall |-> out_valid, "in_stall without a held result")
  `ASSERT_CLK(a_end_gives_result, frame_done |=> out_valid, "frame end gave no result")
  `ASSERT_CLK(a_err3_after_prev, err3_r |-> (have_prev_r && !prev_many_up_r),
              "reappear flagged without a checked previous frame")
  `ASSERT_CLK(a_id_only_on_reappear,
              (out_valid && (out_verdict != mfcc_pkg::V_REAPPEAR)) |-> (out_offending_id == '0),
              "offending id set on a verdict other than reappear")

endmodule

// ===== verif/touch_verdict_checker.sv =====
`timescale 1ns / 1ps

module touch_verdict_checker #(
  parameter int MAXT = mfcc_pkg::MAX_TOUCHES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [mfcc_pkg::ID_W-1:0]      in_contact_id,
  input  logic [mfcc_pkg::ACT_W-1:0]     in_contact_action,
  input  logic                           in_frame_end,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [mfcc_pkg::VERDICT_W-1:0] out_verdict,
  input  logic [mfcc_pkg::ID_W-1:0]      out_offending_id,
  input  logic                           out_transition_warning,
  input  logic                           end_of_test,
  output int                             fail_count,
  output int                             pending
);

  // previous frame as last committed, current frame being collected
  logic [mfcc_pkg::ID_W-1:0]  last_ids [MAXT];
  logic [mfcc_pkg::ACT_W-1:0] last_acts[MAXT];
  int               last_n = 0;
  logic [mfcc_pkg::ID_W-1:0]  cur_ids  [MAXT];
  logic [mfcc_pkg::ACT_W-1:0] cur_acts [MAXT];
  int               cur_n = 0;
  bit               cur_overflow = 1'b0;
  bit               seen_frame = 1'b0;

  mfcc_pkg::res_t verdicts_due[$];
  mfcc_pkg::res_t want;
  int   mismatches = 0;
  int   due_count = 0;
  bit   wrapped_up = 1'b0;

  assign fail_count = mismatches;
  assign pending    = due_count;

  task automatic flag_error(input string what);
    $display("%0t touch_verdict_checker: %s", $time, what);
    mismatches++;
  endtask

  function automatic bit pressed(input logic [mfcc_pkg::ACT_W-1:0] a);
    return (a == mfcc_pkg::ACT_DOWN) || (a == mfcc_pkg::ACT_CHANGE);
  endfunction

  // verdict for the frame now in cur_*, judged against last_*
  function automatic mfcc_pkg::res_t judge_frame();
    mfcc_pkg::res_t  r;
    int              i, j, k, lifted;
    bit              dup, found, trans, warn;
    logic [MAXT-1:0] taken;
    r = '0;
    if (cur_overflow) begin
      r.verdict = mfcc_pkg::V_OVERFLOW;
      return r;
    end
    if (!seen_frame) begin
      r.verdict = mfcc_pkg::V_FIRST;
      return r;
    end
    // distinct lifted ids in the previous frame
    lifted = 0;
    for (i = 0; i < last_n; i++) begin
      if (!pressed(last_acts[i])) begin
        dup = 1'b0;
        for (j = 0; j < i; j++)
          if (!pressed(last_acts[j]) && last_ids[j] == last_ids[i]) dup = 1'b1;
        if (!dup) lifted++;
      end
    end
    if (lifted > 1) begin
      r.verdict = mfcc_pkg::V_MANY_UP;
      return r;
    end
    taken = '0;
    trans = 1'b0;
    warn  = 1'b0;
    for (k = 0; k < cur_n; k++) begin
      for (i = 0; i < last_n; i++) begin
        if (!pressed(last_acts[i]) && last_ids[i] == cur_ids[k]) begin
          r.verdict      = mfcc_pkg::V_REAPPEAR;
          r.offending_id = cur_ids[k];
          r.warning      = warn;
          return r;
        end
      end
      found = 1'b0;
      for (i = 0; i < last_n; i++)
        if (pressed(last_acts[i]) && last_ids[i] == cur_ids[k] && !taken[i]) found = 1'b1;
      if (found) begin
        for (i = 0; i < last_n; i++)
          if (pressed(last_acts[i]) && last_ids[i] == cur_ids[k]) taken[i] = 1'b1;
      end else if (cur_acts[k] == mfcc_pkg::ACT_DOWN) begin
        warn  = warn | trans;
        trans = 1'b1;
      end
      if (cur_acts[k] == mfcc_pkg::ACT_UP) begin
        warn  = warn | trans;
        trans = 1'b1;
      end
    end
    r.warning = warn;
    for (i = 0; i < last_n; i++) begin
      if (pressed(last_acts[i]) && !taken[i]) begin
        r.verdict = mfcc_pkg::V_MISSING;
        return r;
      end
    end
    r.verdict = mfcc_pkg::V_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      last_n       = 0;
      cur_n        = 0;
      cur_overflow = 1'b0;
      seen_frame   = 1'b0;
      verdicts_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_n < MAXT) begin
          cur_ids[cur_n]  = in_contact_id;
          cur_acts[cur_n] = in_contact_action;
          cur_n++;
        end else begin
          cur_overflow = 1'b1;
        end
        if (in_frame_end) begin
          verdicts_due.push_back(judge_frame());
          last_ids     = cur_ids;
          last_acts    = cur_acts;
          last_n       = cur_n;
          seen_frame   = 1'b1;
          cur_n        = 0;
          cur_overflow = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          flag_error($sformatf("result with nothing expected, verdict %0d", out_verdict));
        end else begin
          want = verdicts_due.pop_front();
          if (out_verdict !== want.verdict)
            flag_error($sformatf("verdict %0d, expected %0d", out_verdict, want.verdict));
          if (out_offending_id !== want.offending_id)
            flag_error($sformatf("offending_id %h, expected %h",
                                 out_offending_id, want.offending_id));
          if (out_transition_warning !== want.warning)
            flag_error($sformatf("transition_warning %b, expected %b (verdict %0d)",
                                 out_transition_warning, want.warning, want.verdict));
        end
      end
      if (end_of_test && !wrapped_up) begin
        wrapped_up = 1'b1;
        if (verdicts_due.size() != 0)
          flag_error($sformatf("%0d results never arrived", verdicts_due.size()));
      end
    end
    due_count = verdicts_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int MAXT      = mfcc_pkg::MAX_TOUCHES_DEF;
  localparam int ID_W      = mfcc_pkg::ID_W;
  localparam int ACT_W     = mfcc_pkg::ACT_W;
  localparam int VERDICT_W = mfcc_pkg::VERDICT_W;
  // action code outside the defined set; counts as lifted in the previous frame
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // length of the forced out_stall stretch in the pressure phase
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [ACT_W-1:0] act;
  } touch_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ID_W-1:0]      in_contact_id = '0;
  logic [ACT_W-1:0]     in_contact_action = '0;
  logic                 in_frame_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VERDICT_W-1:0] out_verdict;
  logic [ID_W-1:0]      out_offending_id;
  logic                 out_transition_warning;
  logic                 end_of_test = 1'b0;
  int                   fail_count;
  int                   pending;

  // channel pacing, changed between phases
  int idle_pct = 0;
  int stall_pct = 0;
  // pressure requests: stimulus bumps hold_reqs, the receiver catches up
  int hold_reqs = 0;
  int hold_done = 0;
  int items_sent = 0;

  // frame being built, and what the last sent frame left behind
  touch_t          frame_q[$];
  logic [ID_W-1:0] held_ids[$];
  logic [ID_W-1:0] gone_ids[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multitouch_frame_consistency_checker uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_contact_id          (in_contact_id),
    .in_contact_action      (in_contact_action),
    .in_frame_end           (in_frame_end),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_verdict            (out_verdict),
    .out_offending_id       (out_offending_id),
    .out_transition_warning (out_transition_warning)
  );

  touch_verdict_checker #(.MAXT(MAXT)) u_verdict_chk (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_contact_id          (in_contact_id),
    .in_contact_action      (in_contact_action),
    .in_frame_end           (in_frame_end),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_verdict            (out_verdict),
    .out_offending_id       (out_offending_id),
    .out_transition_warning (out_transition_warning),
    .end_of_test            (end_of_test),
    .fail_count             (fail_count),
    .pending                (pending)
  );

  // Drive one contact item and hold it until the block takes it.
  // Everything is driven by NBA right after the edge, and in_stall is read
  // right after the edge, so we see the value the block sampled at that edge.
  task automatic put_contact(input logic [ID_W-1:0] id, input logic [ACT_W-1:0] act,
                             input logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_contact_id     <= id;
    in_contact_action <= act;
    in_frame_end      <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send frame_q as one frame, then note which ids stay pressed and which
  // were lifted. Contacts past MAXT are dropped by the block, so skip them.
  task automatic send_frame();
    int k;
    for (k = 0; k < frame_q.size(); k++)
      put_contact(frame_q[k].id, frame_q[k].act, k == frame_q.size() - 1);
    held_ids.delete();
    gone_ids.delete();
    for (k = 0; k < frame_q.size() && k < MAXT; k++) begin
      if (frame_q[k].act == mfcc_pkg::ACT_DOWN || frame_q[k].act == mfcc_pkg::ACT_CHANGE)
        held_ids.push_back(frame_q[k].id);
      else
        gone_ids.push_back(frame_q[k].id);
    end
  endtask

  // Random frames until n more items have gone in. Most frames follow on
  // from the last one (held contacts carried over, one lifted now and then,
  // a few new downs) so the checks past the first stage get exercised; the
  // rest is noise from a tiny id pool (duplicates) and oversized frames.
  task automatic run_phase(input int n, input int idle, input int stall);
    int              target, mode, cnt, lift, r, k, j;
    logic [ACT_W-1:0] act;
    touch_t          tmp;
    idle_pct  = idle;
    stall_pct = stall;
    target    = items_sent + n;
    while (items_sent < target) begin
      frame_q.delete();
      mode = $urandom_range(99);
      if (mode < 6) begin
        cnt = $urandom_range(1, 6);
        repeat (cnt)
          frame_q.push_back('{ID_W'($urandom_range(0, 7)), ACT_W'($urandom_range(0, 3))});
      end else if (mode < 10) begin
        cnt = $urandom_range(MAXT + 1, MAXT + 4);
        repeat (cnt) frame_q.push_back('{ID_W'($urandom), ACT_W'($urandom_range(0, 3))});
      end else begin
        lift = (held_ids.size() > 0 && $urandom_range(99) < 35) ?
               $urandom_range(held_ids.size() - 1) : -1;
        foreach (held_ids[i]) begin
          r = $urandom_range(99);
          if (r < 3) continue;  // leave a required contact out
          // lift more eagerly once many fingers are down
          if (i == lift || r < (held_ids.size() > 8 ? 30 : 5)) act = mfcc_pkg::ACT_UP;
          else if (r < 12) act = mfcc_pkg::ACT_DOWN;
          else act = mfcc_pkg::ACT_CHANGE;
          frame_q.push_back('{held_ids[i], act});
        end
        cnt = $urandom_range(0, 2);
        if (frame_q.size() == 0) cnt = 1;
        repeat (cnt) frame_q.push_back('{ID_W'($urandom), mfcc_pkg::ACT_DOWN});
        if (gone_ids.size() > 0 && $urandom_range(99) < 5)
          frame_q.push_back('{gone_ids[$urandom_range(gone_ids.size() - 1)],
                              ACT_W'($urandom_range(0, 2))});
        if ($urandom_range(99) < 3) frame_q.push_back('{ID_W'($urandom), ACT_UNUSED});
        while (frame_q.size() > MAXT) void'(frame_q.pop_back());
        for (k = frame_q.size() - 1; k > 0; k--) begin
          j          = $urandom_range(k);
          tmp        = frame_q[k];
          frame_q[k] = frame_q[j];
          frame_q[j] = tmp;
        end
      end
      send_frame();
    end
  endtask

  // Receiver: random out_stall, or a long forced hold when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_done) begin
        hold_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames, back to back:
    // first frame is only recorded
    frame_q = '{'{16'h0000, mfcc_pkg::ACT_DOWN}, '{16'hFFFF, mfcc_pkg::ACT_CHANGE}};
    send_frame();
    // held ones carried, one lift plus one new down -> ok with warning
    frame_q = '{'{16'h0000, mfcc_pkg::ACT_CHANGE}, '{16'hFFFF, mfcc_pkg::ACT_UP},
                '{16'h1234, mfcc_pkg::ACT_DOWN}};
    send_frame();
    // lifted id comes back, no transition before it
    frame_q = '{'{16'h0000, mfcc_pkg::ACT_CHANGE}, '{16'hFFFF, mfcc_pkg::ACT_DOWN}};
    send_frame();
    // both lifted; the unused action code raises no transition but counts as lifted
    frame_q = '{'{16'h0000, mfcc_pkg::ACT_UP}, '{16'hFFFF, mfcc_pkg::ACT_UP},
                '{16'h5555, ACT_UNUSED}};
    send_frame();
    // three distinct lifted ids in the previous frame
    frame_q = '{'{16'h7777, mfcc_pkg::ACT_DOWN}};
    send_frame();
    // held 7777 gone without a lift
    frame_q = '{'{16'h8888, mfcc_pkg::ACT_DOWN}};
    send_frame();
    // duplicate ids: second 8888 is new, same up id twice
    frame_q = '{'{16'h8888, mfcc_pkg::ACT_CHANGE}, '{16'h8888, mfcc_pkg::ACT_CHANGE},
                '{16'hAAAA, mfcc_pkg::ACT_UP}, '{16'hAAAA, mfcc_pkg::ACT_UP}};
    send_frame();
    // duplicated held id matched once; repeated up id is one lift
    frame_q = '{'{16'h8888, mfcc_pkg::ACT_CHANGE}, '{16'h8888, mfcc_pkg::ACT_CHANGE}};
    send_frame();
    frame_q = '{'{16'h8888, mfcc_pkg::ACT_UP}, '{16'h8888, mfcc_pkg::ACT_CHANGE}};
    send_frame();
    // reappearance after two new downs: warning counts those only
    frame_q = '{'{16'h3333, mfcc_pkg::ACT_DOWN}, '{16'h4444, mfcc_pkg::ACT_DOWN},
                '{16'h8888, mfcc_pkg::ACT_CHANGE}};
    send_frame();

    // random part in pacing phases
    run_phase(120, 0, 0);
    run_phase(120, 76, 0);
    run_phase(120, 0, 76);
    run_phase(120, 12, 12);
    // long receiver hold while items keep coming: the block must back up
    hold_reqs <= hold_reqs + 1;
    run_phase(120, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (6) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
